// File: rtl/swcrc_pkg.sv
package swcrc_pkg;

  typedef enum logic [1:0] {
    MODE_CRC8  = 2'd0,
    MODE_CRC10 = 2'd1,
    MODE_CRC16 = 2'd2,
    MODE_CRC32 = 2'd3
  } crc_mode_e;

  localparam int unsigned CrcW  = 32;
  localparam int unsigned ByteW = 8;
  localparam int unsigned TopW  = 5;

  localparam logic [CrcW-1:0] Poly8  = 32'h0000_00D5;
  localparam logic [CrcW-1:0] Poly10 = 32'h0000_0233;
  localparam logic [CrcW-1:0] Poly16 = 32'h0000_1021;
  localparam logic [CrcW-1:0] Poly32 = 32'h04C1_1DB7;

  localparam logic [CrcW-1:0] Mask8  = 32'h0000_00FF;
  localparam logic [CrcW-1:0] Mask10 = 32'h0000_03FF;
  localparam logic [CrcW-1:0] Mask16 = 32'h0000_FFFF;
  localparam logic [CrcW-1:0] Mask32 = 32'hFFFF_FFFF;

  typedef logic [CrcW-1:0] crc_t;

endpackage

// File: rtl/swcrc_if.sv
interface swcrc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       start_of_message;
  logic       end_of_message;

  modport source (output valid, output data_byte, output start_of_message,
                  output end_of_message, input ready);
  modport sink   (input valid, input data_byte, input start_of_message,
                  input end_of_message, output ready);
endinterface

interface swcrc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] crc_value;
  logic        crc_is_zero;

  modport source (output valid, output crc_value, output crc_is_zero, input ready);
  modport sink   (input valid, input crc_value, input crc_is_zero, output ready);
endinterface

interface swcrc_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] crc_mode;

  modport source (output valid, output crc_mode, input ready);
  modport sink   (input valid, input crc_mode, output ready);
endinterface

// File: rtl/selectable_width_crc_top.sv
// Selectable-width CRC, MSB first, non-reflected, zero init, no final xor.
//
// Channels:
//   in_i  - one message byte per beat, with start and end marks.
//   out_o - one beat per message: remainder masked to the width, zero flag.
//   cfg_i - writes the 2-bit polynomial select (8/10/16/32); always ready.
//           Write it only while no message is in flight.
// Flow: a byte is captured in the input register on its beat; from there
//   it is folded into the remainder and, if it carries the end mark, the
//   result is loaded into the output register as the remainder updates.
//   Throughput: one byte per cycle while no end-marked byte waits; the
//   combinational eight-step fold feeds the remainder register.
// Stall: bytes without an end mark keep flowing while a result waits; a byte
//   with an end mark waits in the input register until the output register
//   frees up, and in_i.ready drops only then.
// Reset: remainder clears to zero, mode to crc8, both stages empty.
module selectable_width_crc_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  swcrc_in_if.sink      in_i,
  swcrc_cfg_if.sink     cfg_i,
  swcrc_out_if.source   out_o
);
  import swcrc_pkg::*;

  // mode register
  crc_mode_e mode_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_CRC8;
    end else if (cfg_i.valid) begin
      mode_q <= crc_mode_e'(cfg_i.crc_mode);
    end
  end

  // input register
  logic       a_valid_q;
  logic [7:0] a_byte_q;
  logic       a_sof_q;
  logic       a_eof_q;
  logic       out_free;
  logic       advance;
  logic       in_take;

  assign out_free = !out_o.valid || out_o.ready;
  assign advance  = a_valid_q && (!a_eof_q || out_free);
  assign in_i.ready = !a_valid_q || advance;
  assign in_take  = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      a_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      a_byte_q <= in_i.data_byte;
      a_sof_q  <= in_i.start_of_message;
      a_eof_q  <= in_i.end_of_message;
    end
  end

  // fold
  crc_t rem_q;
  crc_t rem_d;
  crc_t rem_in;

  assign rem_in = a_sof_q ? '0 : rem_q;

  swcrc_fold u_fold (
    .mode_i (mode_q),
    .rem_i  (rem_in),
    .byte_i (a_byte_q),
    .rem_o  (rem_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
    end else if (advance) begin
      rem_q <= rem_d;
    end
  end

  // output register
  logic out_valid_q;
  crc_t out_crc_q;
  logic out_zero_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= advance && a_eof_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && a_eof_q) begin
      out_crc_q  <= rem_d;
      out_zero_q <= (rem_d == '0);
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.crc_value   = out_crc_q;
  assign out_o.crc_is_zero = out_zero_q;

`ifndef ASSERT_OFF
  a_eof_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && a_eof_q |=> out_valid_q)
    else $error("end byte advanced without a result");

  a_zero_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_zero_q == (out_crc_q == '0)))
    else $error("zero flag disagrees with crc value");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (a_valid_q && a_eof_q && out_valid_q && !out_o.ready))
    else $error("input stalled without a blocked end byte");
`endif

endmodule

// File: rtl/swcrc_fold.sv
module swcrc_fold (
  input  swcrc_pkg::crc_mode_e mode_i,
  input  swcrc_pkg::crc_t      rem_i,
  input  logic [7:0]           byte_i,
  output swcrc_pkg::crc_t      rem_o
);
  import swcrc_pkg::*;

  crc_t            mask;
  crc_t            poly;
  logic [TopW-1:0] top_idx;
  logic [TopW-1:0] shamt;

  always_comb begin
    unique case (mode_i)
      MODE_CRC8: begin
        mask = Mask8;  poly = Poly8;  top_idx = TopW'(7);  shamt = TopW'(0);
      end
      MODE_CRC10: begin
        mask = Mask10; poly = Poly10; top_idx = TopW'(9);  shamt = TopW'(2);
      end
      MODE_CRC16: begin
        mask = Mask16; poly = Poly16; top_idx = TopW'(15); shamt = TopW'(8);
      end
      default: begin
        mask = Mask32; poly = Poly32; top_idx = TopW'(31); shamt = TopW'(24);
      end
    endcase
  end

  // byte lands on the top eight bits, then eight shift / xor steps
  always_comb begin
    crc_t rem;
    logic top;
    rem = rem_i & mask;
    rem = (rem ^ (crc_t'(byte_i) << shamt)) & mask;
    for (int i = 0; i < ByteW; i++) begin
      top = rem[top_idx];
      rem = (rem << 1) & mask;
      if (top) begin
        rem = rem ^ poly;
      end
    end
    rem_o = rem;
  end

endmodule

// File: tb/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import swcrc_pkg::*;

  // One expected result beat: masked remainder and its zero flag.
  typedef struct packed {
    crc_t crc_value;
    logic crc_is_zero;
  } crc_result_t;

  // Cycles with no beat on any channel before the run is called hung.
  localparam int unsigned QuietLimit = 2000;
  // Random input items in the traffic test.
  localparam int unsigned RandomItems = 1050;
  // Bytes without an end mark fold in the cycle after their beat; this covers it.
  localparam int unsigned SettleCycles = 4;

  logic clk_i;
  logic rst_ni;

  swcrc_in_if  in_if();
  swcrc_cfg_if cfg_if();
  swcrc_out_if out_if();

  selectable_width_crc_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .cfg_i  (cfg_if),
    .out_o  (out_if)
  );

  // 4 ns clock.
  initial clk_i = 1'b0;
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Shared testbench state.
  crc_result_t pending_crc_q[$];  // results still owed by the block, oldest first
  crc_mode_e   model_mode;        // polynomial select as the block should see it
  crc_t        model_rem;         // running remainder as the block should hold it
  crc_mode_e   cur_mode;          // last select written, for building check bytes
  int unsigned error_count;
  int unsigned items_sent;
  int unsigned quiet_cycles;
  int unsigned stall_left;
  int unsigned gap_pct;           // chance in percent of a gap before an input beat
  int unsigned stall_pct;         // chance in percent of an output stall burst
  bit          idle_on;           // cleared for the final stretch of traffic

  // One message byte folded into the remainder, MSB first.
  function automatic crc_t fold_crc_byte(crc_t rem, logic [7:0] data, crc_mode_e mode);
    crc_t        poly;
    crc_t        mask;
    int unsigned width;
    logic        top;
    int unsigned i;
    case (mode)
      MODE_CRC8: begin
        poly = Poly8;  mask = Mask8;  width = 8;
      end
      MODE_CRC10: begin
        poly = Poly10; mask = Mask10; width = 10;
      end
      MODE_CRC16: begin
        poly = Poly16; mask = Mask16; width = 16;
      end
      default: begin
        poly = Poly32; mask = Mask32; width = 32;
      end
    endcase
    // Remainder may still carry bits of a wider mode; drop them first.
    rem = rem & mask;
    rem = rem ^ (crc_t'(data) << (width - ByteW));
    rem = rem & mask;
    for (i = 0; i < ByteW; i++) begin
      top = rem[width-1];
      rem = (rem << 1) & mask;
      if (top) begin
        rem = rem ^ poly;
      end
    end
    return rem & mask;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] exp_v, logic [31:0] got_v);
    $display("%0t ns: %s mismatch, expected %h, got %h", $time, what, exp_v, got_v);
    error_count++;
  endtask

  // Input beat monitor: tracks the select and remainder, queues a result on
  // every end-marked byte. Config beats only ever land while traffic is idle.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_if.valid && cfg_if.ready) begin
        model_mode = crc_mode_e'(cfg_if.crc_mode);
      end
      if (in_if.valid && in_if.ready) begin
        if (in_if.start_of_message) begin
          model_rem = '0;
        end
        model_rem = fold_crc_byte(model_rem, in_if.data_byte, model_mode);
        if (in_if.end_of_message) begin
          pending_crc_q.push_back('{crc_value: model_rem, crc_is_zero: (model_rem == '0)});
        end
      end
    end
  end

  // Output beat checker: each beat is matched against the oldest expectation.
  always @(posedge clk_i) begin
    crc_result_t exp_r;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pending_crc_q.size() == 0) begin
        report_mismatch("unexpected result beat", '0, out_if.crc_value);
      end else begin
        exp_r = pending_crc_q.pop_front();
        if (out_if.crc_value !== exp_r.crc_value) begin
          report_mismatch("crc_value", exp_r.crc_value, out_if.crc_value);
        end
        if (out_if.crc_is_zero !== exp_r.crc_is_zero) begin
          report_mismatch("crc_is_zero", 32'(exp_r.crc_is_zero), 32'(out_if.crc_is_zero));
        end
      end
    end
  end

  // Output back-pressure: stall bursts of random length at a per-phase rate.
  always @(posedge clk_i) begin
    if (idle_on && stall_left == 0 && $urandom_range(99) < stall_pct) begin
      stall_left = $urandom_range(19, 1);
    end
    if (idle_on && stall_left != 0) begin
      out_if.ready <= 1'b0;
      stall_left--;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // Hang detection: count cycles with no beat on any channel.
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    while (quiet_cycles < QuietLimit) @(posedge clk_i);
    $display("%0t ns: no beat for %0d cycles", $time, QuietLimit);
    $display("*** FAILED ***");
    $finish;
  end

  // Sends one byte beat. Valid is left high on return so back-to-back bytes
  // keep the channel busy; a gap or a config write lowers it.
  task automatic send_byte(logic [7:0] data, logic som, logic eom);
    int unsigned gap;
    if (idle_on && $urandom_range(99) < gap_pct) begin
      gap = $urandom_range(19, 1);
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid            <= 1'b1;
    in_if.data_byte        <= data;
    in_if.start_of_message <= som;
    in_if.end_of_message   <= eom;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    items_sent++;
  endtask

  // Mode writes happen only with the block drained: no result owed and the
  // last unmarked bytes folded.
  task automatic write_crc_mode(crc_mode_e mode);
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_crc_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    cfg_if.valid    <= 1'b1;
    cfg_if.crc_mode <= mode;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    cfg_if.valid <= 1'b0;
    cur_mode = mode;
  endtask

  // Well-formed message of random bytes. With add_crc the remainder is
  // appended MSB first, which must drive the remainder to zero (byte widths).
  task automatic send_message(int unsigned len, bit add_crc);
    crc_t        rem;
    int unsigned crc_bytes;
    int unsigned k;
    logic [7:0]  data;
    rem = '0;
    case (cur_mode)
      MODE_CRC8:  crc_bytes = 1;
      MODE_CRC16: crc_bytes = 2;
      MODE_CRC32: crc_bytes = 4;
      default:    crc_bytes = 0;
    endcase
    if (!add_crc) begin
      crc_bytes = 0;
    end
    for (k = 0; k < len; k++) begin
      data = 8'($urandom);
      rem  = fold_crc_byte(rem, data, cur_mode);
      send_byte(data, k == 0, (k == len - 1) && crc_bytes == 0);
    end
    for (k = 0; k < crc_bytes; k++) begin
      send_byte(8'(rem >> (8 * (crc_bytes - 1 - k))), 1'b0, k == crc_bytes - 1);
    end
  endtask

  // Reset select is crc8; nothing written yet.
  task automatic test_reset_mode();
    send_byte(8'hFF, 1'b1, 1'b1);
  endtask

  // Every polynomial: an all-zero message (zero flag set), then the bytes
  // FF and 01 across a two-byte message.
  task automatic test_each_polynomial();
    crc_mode_e modes[4];
    int unsigned m;
    modes = '{MODE_CRC8, MODE_CRC10, MODE_CRC16, MODE_CRC32};
    for (m = 0; m < 4; m++) begin
      write_crc_mode(modes[m]);
      send_byte(8'h00, 1'b1, 1'b1);
      send_byte(8'hFF, 1'b1, 1'b0);
      send_byte(8'h01, 1'b0, 1'b1);
    end
  endtask

  // A 32-bit remainder carried into crc8 mid-message: it is cut to 8 bits.
  task automatic test_mode_switch_mid_message();
    write_crc_mode(MODE_CRC32);
    send_byte(8'hA5, 1'b1, 1'b0);
    write_crc_mode(MODE_CRC8);
    send_byte(8'h3C, 1'b0, 1'b1);
  endtask

  // A second start mark inside a message throws away the bytes before it.
  task automatic test_restart_mid_message();
    send_byte(8'h5A, 1'b1, 1'b0);
    send_byte(8'hC3, 1'b1, 1'b1);
  endtask

  // Message plus its own crc16 must report a zero remainder.
  task automatic test_check_function();
    write_crc_mode(MODE_CRC16);
    send_message(1, 1'b1);
  endtask

  // Phases of random traffic, each under a random mode and idle rate. Most
  // of it is well-formed messages, some with their crc appended; the rest is
  // single bytes with random marks. The last stretch runs without idling.
  task automatic test_random_traffic();
    int unsigned first_item;
    int unsigned phase_end;
    int unsigned len;
    first_item = items_sent;
    while (items_sent - first_item < RandomItems) begin
      write_crc_mode(crc_mode_e'($urandom_range(3)));
      case ($urandom_range(2))
        0: begin
          gap_pct = 0;  stall_pct = 0;
        end
        1: begin
          gap_pct = 10; stall_pct = 10;
        end
        default: begin
          gap_pct = 30; stall_pct = 25;
        end
      endcase
      phase_end = items_sent + 120;
      while (items_sent < phase_end && items_sent - first_item < RandomItems) begin
        if (items_sent - first_item >= RandomItems - 150) begin
          idle_on = 1'b0;
        end
        if ($urandom_range(99) < 85) begin
          len = ($urandom_range(9) == 0) ? $urandom_range(64, 13) : $urandom_range(12, 1);
          send_message(len, $urandom_range(9) == 0);
        end else begin
          send_byte(8'($urandom), $urandom_range(3) == 0, $urandom_range(3) == 0);
        end
      end
    end
  endtask

  initial begin
    // Known values on every input from time zero.
    rst_ni                 = 1'b0;
    in_if.valid            = 1'b0;
    in_if.data_byte        = '0;
    in_if.start_of_message = 1'b0;
    in_if.end_of_message   = 1'b0;
    cfg_if.valid           = 1'b0;
    cfg_if.crc_mode        = MODE_CRC8;
    out_if.ready           = 1'b1;
    model_mode             = MODE_CRC8;
    model_rem              = '0;
    cur_mode               = MODE_CRC8;
    error_count            = 0;
    items_sent             = 0;
    quiet_cycles           = 0;
    stall_left             = 0;
    idle_on                = 1'b1;
    gap_pct                = 20;
    stall_pct              = 20;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_mode();
    test_each_polynomial();
    test_mode_switch_mid_message();
    test_restart_mid_message();
    test_check_function();
    test_random_traffic();

    // Drain: every owed result back, then a wait for stray beats.
    in_if.valid <= 1'b0;
    idle_on = 1'b0;
    while (pending_crc_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/swcrc_pkg.sv
rtl/swcrc_if.sv
rtl/swcrc_fold.sv
rtl/selectable_width_crc_top.sv
tb/tb_top.sv
